FILE: rtl/dmv_pkg.sv
package dmv_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_HEADER = 4'd0;
	localparam logic [PHASE_W-1:0] PH_NAME   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_LABEL  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_PTR2   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_TYPE1  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_TYPE2  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_CLASS1 = 4'd6;
	localparam logic [PHASE_W-1:0] PH_CLASS2 = 4'd7;
	localparam logic [PHASE_W-1:0] PH_TTL    = 4'd8;
	localparam logic [PHASE_W-1:0] PH_RDLEN1 = 4'd9;
	localparam logic [PHASE_W-1:0] PH_RDLEN2 = 4'd10;
	localparam logic [PHASE_W-1:0] PH_RDATA  = 4'd11;
	localparam logic [PHASE_W-1:0] PH_DONE   = 4'd12;
	localparam logic [PHASE_W-1:0] PH_TRAIL  = 4'd13;
	localparam logic [PHASE_W-1:0] PH_ERROR  = 4'd14;

	localparam logic [2:0] ST_VALID    = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_RESERVED = 3'd2;
	localparam logic [2:0] ST_NAME     = 3'd3;
	localparam logic [2:0] ST_POINTER  = 3'd4;
	localparam logic [2:0] ST_TYPE     = 3'd5;
	localparam logic [2:0] ST_CLASS    = 3'd6;

	// one input byte in flight between the two modules
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	// verdict handed to the output stage
	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic       trailing;
	} verdict_t;

	function automatic logic type_ok(input logic [15:0] t);
		return (t >= 16'd1 && t <= 16'd68) || (t >= 16'd99 && t <= 16'd109) ||
			(t >= 16'd249 && t <= 16'd264) || t == 16'd32768 || t == 16'd32769;
	endfunction

endpackage

FILE: rtl/dmv_parser.sv
module dmv_parser #(
	parameter int OFFSET_BITS = dmv_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dmv_pkg::byte_req_t req,
	output dmv_pkg::verdict_t  verdict
);
	import dmv_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	logic [PHASE_W-1:0]     phase_q, phase_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [15:0]            cnt_q [4];
	logic [15:0]            cnt_d [4];
	logic [1:0]             sect_q, sect_d;
	logic [15:0]            recs_q, recs_d;
	logic [15:0]            left_q, left_d;
	logic [7:0]             acc_q, acc_d;
	logic [OFFSET_BITS-1:0] porig_q, porig_d;
	logic [2:0]             err_q, err_d;
	logic [15:0]            word;
	logic [15:0]            recs_dec;
	logic [15:0]            left_dec;
	logic [1:0]             cidx;
	logic                   rec_done;
	logic [2:0]             status;

	assign word     = {acc_q, req.data};
	assign recs_dec = recs_q - 16'd1;
	assign left_dec = left_q - 16'd1;
	assign cidx     = offset_q[2:1] - 2'd2;

	// next-section search over the four counts from the given index on
	function automatic logic [2:0] next_sect(input logic [2:0] s, input logic [15:0] c [4]);
		logic [2:0] r;
		r = 3'd4;
		for (int i = 3; i >= 0; i--)
			if (3'(i) >= s && c[i] != 16'd0) r = 3'(i);
		return r;
	endfunction

	// byte-level parse transition
	always_comb begin
		logic [2:0] ns;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		sect_d  = sect_q;
		recs_d  = recs_q;
		left_d  = left_q;
		acc_d   = acc_q;
		porig_d = porig_q;
		err_d   = err_q;
		rec_done = 1'b0;
		ns = 3'd4;
		case (phase_q)
			PH_HEADER: begin
				if (offset_q == OFFSET_BITS'(3) && (req.data & 8'h70) != 8'h00) begin
					err_d = ST_RESERVED;
					phase_d = PH_ERROR;
				end else begin
					if (offset_q >= OFFSET_BITS'(4) && offset_q <= OFFSET_BITS'(11)) begin
						if (!offset_q[0]) cnt_d[cidx] = {req.data, 8'h00};
						else cnt_d[cidx] = cnt_q[cidx] | {8'h00, req.data};
					end
					if (offset_q == OFFSET_BITS'(11)) begin
						ns = next_sect(3'd0, cnt_d);
						if (ns == 3'd4) phase_d = PH_DONE;
						else begin
							sect_d = ns[1:0];
							recs_d = cnt_d[ns[1:0]];
							phase_d = PH_NAME;
						end
					end
				end
			end
			PH_NAME: begin
				if (req.data == 8'h00) phase_d = PH_TYPE1;
				else if (req.data <= 8'h3f) begin
					left_d = {8'h00, req.data};
					phase_d = PH_LABEL;
				end else if (req.data[7:6] == 2'b11) begin
					acc_d = {2'b00, req.data[5:0]};
					porig_d = offset_q;
					phase_d = PH_PTR2;
				end else begin
					err_d = ST_NAME;
					phase_d = PH_ERROR;
				end
			end
			PH_LABEL: begin
				left_d = left_dec;
				if (left_dec == 16'd0) phase_d = PH_NAME;
			end
			PH_PTR2: begin
				if ({16'd0, word} >= 32'(porig_q)) begin
					err_d = ST_POINTER;
					phase_d = PH_ERROR;
				end else phase_d = PH_TYPE1;
			end
			PH_TYPE1, PH_CLASS1, PH_RDLEN1: begin
				acc_d = req.data;
				phase_d = phase_q + 4'd1;
			end
			PH_TYPE2: begin
				if (!type_ok(word)) begin
					err_d = ST_TYPE;
					phase_d = PH_ERROR;
				end else phase_d = PH_CLASS1;
			end
			PH_CLASS2: begin
				if (sect_q == 2'd0) begin
					if (!((word >= 16'd1 && word <= 16'd4) || word == 16'd254 ||
						word == 16'd255)) begin
						err_d = ST_CLASS;
						phase_d = PH_ERROR;
					end else rec_done = 1'b1;
				end else if (!(word >= 16'd1 && word <= 16'd4)) begin
					err_d = ST_CLASS;
					phase_d = PH_ERROR;
				end else begin
					left_d = 16'd4;
					phase_d = PH_TTL;
				end
			end
			PH_TTL: begin
				left_d = left_dec;
				if (left_dec == 16'd0) phase_d = PH_RDLEN1;
			end
			PH_RDLEN2: begin
				left_d = word;
				if (word == 16'd0) rec_done = 1'b1;
				else phase_d = PH_RDATA;
			end
			PH_RDATA: begin
				left_d = left_dec;
				if (left_dec == 16'd0) rec_done = 1'b1;
			end
			PH_DONE, PH_TRAIL: phase_d = PH_TRAIL;
			default: ;
		endcase
		// record finished: next record or next nonempty section
		if (rec_done) begin
			recs_d = recs_dec;
			if (recs_dec != 16'd0) phase_d = PH_NAME;
			else begin
				ns = next_sect({1'b0, sect_q} + 3'd1, cnt_q);
				if (ns == 3'd4) phase_d = PH_DONE;
				else begin
					sect_d = ns[1:0];
					recs_d = cnt_q[ns[1:0]];
					phase_d = PH_NAME;
				end
			end
		end
		offset_d = (offset_q != OFF_MAX) ? offset_q + OFFSET_BITS'(1) : offset_q;
	end

	// verdict on the last byte
	always_comb begin
		if (phase_d == PH_ERROR) status = err_d;
		else if (phase_d == PH_DONE || phase_d == PH_TRAIL) status = ST_VALID;
		else status = ST_TRUNC;
	end

	// parse state, back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			offset_q <= '0;
			cnt_q    <= '{default: 16'd0};
			sect_q   <= '0;
			recs_q   <= '0;
			left_q   <= '0;
			acc_q    <= '0;
			porig_q  <= '0;
			err_q    <= ST_VALID;
		end else if (req.valid) begin
			if (req.last) begin
				phase_q  <= PH_HEADER;
				offset_q <= '0;
				cnt_q    <= '{default: 16'd0};
				sect_q   <= '0;
				recs_q   <= '0;
				left_q   <= '0;
				acc_q    <= '0;
				porig_q  <= '0;
				err_q    <= ST_VALID;
			end else begin
				phase_q  <= phase_d;
				offset_q <= offset_d;
				cnt_q    <= cnt_d;
				sect_q   <= sect_d;
				recs_q   <= recs_d;
				left_q   <= left_d;
				acc_q    <= acc_d;
				porig_q  <= porig_d;
				err_q    <= err_d;
			end
		end
	end

	assign verdict.valid    = req.valid && req.last;
	assign verdict.status   = status;
	assign verdict.trailing = (phase_d == PH_TRAIL);

endmodule

FILE: rtl/dns_message_validator_core.sv
// DNS message checker. Bytes arrive on the s_axis side, one per cycle while tready is
// high, with tlast on the final byte; one verdict per message comes out on m_axis. Throughput
// is one byte per cycle, no gaps between messages, while tready is high. An accepted byte
// passes the input register, then the combinational parse into the verdict buffer.
// A two-entry output buffer keeps tready high while under two verdicts are held or pending.
module dns_message_validator_core #(
	parameter int OFFSET_BITS = dmv_pkg::OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [2:0] status, [3] trailing_bytes, zero fill
);
	import dmv_pkg::*;

	byte_req_t  in_s1;
	verdict_t   verdict;
	logic [3:0] fifo_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	// input register; space is reserved for a verdict still in flight
	assign s_axis_tready = (cnt_q + 2'(in_s1.valid && in_s1.last)) < 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else begin
			in_s1.valid <= s_axis_tvalid && s_axis_tready;
			in_s1.data  <= s_axis_tdata;
			in_s1.last  <= s_axis_tlast;
		end
	end

	dmv_parser #(.OFFSET_BITS(OFFSET_BITS)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (in_s1),
		.verdict (verdict)
	);

	// two-entry verdict buffer
	assign push = verdict.valid;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= {verdict.trailing, verdict.status};
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = {4'h0, fifo_q[rd_q]};

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == 2'd2)) else $error("verdict buffer overflow");
	a_trail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.trailing |-> verdict.status == ST_VALID)
		else $error("trailing flag with error status");
	a_verdict_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> verdict.valid)
		else $error("verdict missing");
`endif

endmodule
